// File: sv/mbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mini UART bit engine package
// Shared types and constants for the transmitter/receiver bit engine.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int unsigned BaudW    = 16;
  localparam int unsigned AccW     = 17;
  localparam int unsigned CyclesW  = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitCntW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [BitCntW-1:0] LenShort = 4'd7;
  localparam logic [BitCntW-1:0] LenLong  = 4'd8;

  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_WRITE_TX  = 2'd1,
    FUNC_CLR_READY = 2'd2,
    FUNC_CLR_IRQ   = 2'd3
  } mbe_func_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_DATA  = 2'd1,
    PH_STOP  = 2'd2,
    PH_END   = 2'd3
  } mbe_phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BAUD_COUNT      = 3'd0,
    REG_EIGHT_BIT_CHARS = 3'd1,
    REG_TX_ENABLE       = 3'd2,
    REG_RX_ENABLE       = 3'd3,
    REG_RX_IRQ_ENABLE   = 3'd4,
    REG_TX_IRQ_ENABLE   = 3'd5,
    REG_UART_ENABLE     = 3'd6
  } mbe_reg_e;

  typedef struct packed {
    logic [BaudW-1:0] baud_count;
    logic             eight_bit_chars;
    logic             tx_enable;
    logic             rx_enable;
    logic             rx_irq_enable;
    logic             tx_irq_enable;
    logic             uart_enable;
  } mbe_cfg_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [CyclesW-1:0] cycles;
    logic               rx_pin;
    logic [ByteW-1:0]   tx_byte;
  } mbe_item_t;

  typedef struct packed {
    logic             tx_pin;
    logic [ByteW-1:0] rx_data;
    logic             rx_avail;
    logic             tx_empty;
    logic             irq_pending;
    logic             irq_signal;
    logic             frame_error;
  } mbe_result_t;

endpackage
`default_nettype wire

// File: sv/mbe_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mini UART bit engine input channel
// Valid/ready channel carrying one command or tick item.
// ----------------------------------------------------------------------------
interface mbe_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [mbe_pkg::CyclesW-1:0] cycles;
  logic                        rx_pin;
  logic [mbe_pkg::ByteW-1:0]   tx_byte;

  modport source (output valid, func, cycles, rx_pin, tx_byte, input ready);
  modport sink   (input valid, func, cycles, rx_pin, tx_byte, output ready);
endinterface
`default_nettype wire

// File: sv/mbe_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mini UART bit engine output channel
// Valid/ready channel carrying the line and status snapshot after each item.
// ----------------------------------------------------------------------------
interface mbe_out_if;
  logic                      valid;
  logic                      ready;
  logic                      tx_pin;
  logic [mbe_pkg::ByteW-1:0] rx_data;
  logic                      rx_avail;
  logic                      tx_empty;
  logic                      irq_pending;
  logic                      irq_signal;
  logic                      frame_error;

  modport source (output valid, tx_pin, rx_data, rx_avail, tx_empty, irq_pending,
                  irq_signal, frame_error, input ready);
  modport sink   (input valid, tx_pin, rx_data, rx_avail, tx_empty, irq_pending,
                  irq_signal, frame_error, output ready);
endinterface
`default_nettype wire

// File: sv/mbe_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mini UART bit engine configuration registers
// Write-only register file decoded from a register index.
// ----------------------------------------------------------------------------
module mbe_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mbe_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output mbe_pkg::mbe_cfg_t                  cfg_o
);

  mbe_pkg::mbe_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (mbe_pkg::mbe_reg_e'(cfg_idx_i))
        mbe_pkg::REG_BAUD_COUNT:      cfg_d.baud_count      = cfg_wdata_i[mbe_pkg::BaudW-1:0];
        mbe_pkg::REG_EIGHT_BIT_CHARS: cfg_d.eight_bit_chars = cfg_wdata_i[0];
        mbe_pkg::REG_TX_ENABLE:       cfg_d.tx_enable       = cfg_wdata_i[0];
        mbe_pkg::REG_RX_ENABLE:       cfg_d.rx_enable       = cfg_wdata_i[0];
        mbe_pkg::REG_RX_IRQ_ENABLE:   cfg_d.rx_irq_enable   = cfg_wdata_i[0];
        mbe_pkg::REG_TX_IRQ_ENABLE:   cfg_d.tx_irq_enable   = cfg_wdata_i[0];
        mbe_pkg::REG_UART_ENABLE:     cfg_d.uart_enable     = cfg_wdata_i[0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baud_count      <= '0;
      cfg_q.eight_bit_chars <= 1'b0;
      cfg_q.tx_enable       <= 1'b1;
      cfg_q.rx_enable       <= 1'b1;
      cfg_q.rx_irq_enable   <= 1'b0;
      cfg_q.tx_irq_enable   <= 1'b0;
      cfg_q.uart_enable     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: sv/mbe_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mini UART bit engine input register
// Captures one item per transfer and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module mbe_in_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mbe_pkg::mbe_item_t in_item_i,
  input  wire logic               take_i,
  output logic                    valid_o,
  output mbe_pkg::mbe_item_t      item_o
);

  logic               valid_q, valid_d;
  mbe_pkg::mbe_item_t item_q;
  logic               load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// File: sv/mbe_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mini UART bit engine core logic
// Baud accumulator, transmit and receive bit machines, flags and result register.
// ----------------------------------------------------------------------------
module mbe_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mbe_pkg::mbe_cfg_t  cfg_i,
  input  wire logic               item_valid_i,
  input  wire mbe_pkg::mbe_item_t item_i,
  output logic                    take_o,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output mbe_pkg::mbe_result_t    res_o
);

  logic [mbe_pkg::AccW-1:0]    acc_q, acc_d, acc_sum;
  mbe_pkg::mbe_phase_e         tx_phase_q, tx_phase_d;
  logic [mbe_pkg::BitCntW-1:0] tx_bits_q, tx_bits_d, tx_bits_inc;
  logic [mbe_pkg::ByteW-1:0]   tx_shift_q, tx_shift_d;
  mbe_pkg::mbe_phase_e         rx_phase_q, rx_phase_d;
  logic [mbe_pkg::BitCntW-1:0] rx_bits_q, rx_bits_d, rx_bits_inc;
  logic [mbe_pkg::ByteW-1:0]   rx_shift_q, rx_shift_d;
  logic [mbe_pkg::ByteW-1:0]   holding_q, holding_d;
  logic                        ready_q, ready_d;
  logic                        empty_q, empty_d;
  logic                        pending_q, pending_d;
  logic                        line_q, line_d;
  logic                        res_valid_q, res_valid_d;
  mbe_pkg::mbe_result_t        res_q, res_d;

  mbe_pkg::mbe_func_e          func;
  logic [mbe_pkg::BitCntW-1:0] char_len;
  logic                        is_tick, baud_hit, do_step, tx_run, rx_run;
  logic                        tx_irq, rx_irq, ferr;

  assign take_o = item_valid_i && (!res_valid_q || res_ready_i);

  assign func     = mbe_pkg::mbe_func_e'(item_i.func);
  assign char_len = cfg_i.eight_bit_chars ? mbe_pkg::LenLong : mbe_pkg::LenShort;
  assign is_tick  = (func == mbe_pkg::FUNC_TICK);
  assign acc_sum  = acc_q + mbe_pkg::AccW'(item_i.cycles);
  assign baud_hit = acc_sum >= mbe_pkg::AccW'(cfg_i.baud_count);
  assign do_step  = is_tick && baud_hit && cfg_i.uart_enable;
  assign tx_run   = do_step && !empty_q && cfg_i.tx_enable;
  assign rx_run   = do_step && cfg_i.rx_enable;

  assign tx_bits_inc = tx_bits_q + 4'd1;
  assign rx_bits_inc = rx_bits_q + 4'd1;

  always_comb begin
    acc_d = acc_q;
    if (is_tick) begin
      acc_d = baud_hit ? '0 : acc_sum;
    end
  end

  // Transmit machine: next phase.
  always_comb begin
    tx_phase_d = tx_phase_q;
    if (tx_run) begin
      unique case (tx_phase_q)
        mbe_pkg::PH_START: tx_phase_d = mbe_pkg::PH_DATA;
        mbe_pkg::PH_DATA:  if (tx_bits_inc >= char_len) tx_phase_d = mbe_pkg::PH_STOP;
        mbe_pkg::PH_STOP:  tx_phase_d = mbe_pkg::PH_END;
        mbe_pkg::PH_END:   tx_phase_d = mbe_pkg::PH_START;
      endcase
    end
  end

  // Transmit machine: line, shifter and buffer flag.
  always_comb begin
    line_d     = line_q;
    tx_shift_d = tx_shift_q;
    tx_bits_d  = tx_bits_q;
    empty_d    = empty_q;
    tx_irq     = 1'b0;
    if (func == mbe_pkg::FUNC_WRITE_TX) begin
      tx_shift_d = item_i.tx_byte;
      empty_d    = 1'b0;
    end
    if (tx_run) begin
      unique case (tx_phase_q)
        mbe_pkg::PH_START: line_d = 1'b0;
        mbe_pkg::PH_DATA: begin
          line_d     = tx_shift_q[0];
          tx_shift_d = tx_shift_q >> 1;
          tx_bits_d  = tx_bits_inc;
        end
        mbe_pkg::PH_STOP: line_d = 1'b1;
        mbe_pkg::PH_END: begin
          tx_irq    = cfg_i.tx_irq_enable;
          tx_bits_d = '0;
          line_d    = 1'b1;
          empty_d   = 1'b1;
        end
      endcase
    end
  end

  // Receive machine: next phase.
  always_comb begin
    rx_phase_d = rx_phase_q;
    if (rx_run) begin
      unique case (rx_phase_q)
        mbe_pkg::PH_START: if (!item_i.rx_pin) rx_phase_d = mbe_pkg::PH_DATA;
        mbe_pkg::PH_DATA:  if (rx_bits_inc >= char_len) rx_phase_d = mbe_pkg::PH_STOP;
        mbe_pkg::PH_STOP:  rx_phase_d = mbe_pkg::PH_START;
        mbe_pkg::PH_END:   rx_phase_d = mbe_pkg::PH_START;
      endcase
    end
  end

  // Receive machine: shifter, holding register and status.
  always_comb begin
    rx_shift_d = rx_shift_q;
    rx_bits_d  = rx_bits_q;
    holding_d  = holding_q;
    ready_d    = ready_q;
    rx_irq     = 1'b0;
    ferr       = 1'b0;
    if (func == mbe_pkg::FUNC_CLR_READY) begin
      ready_d = 1'b0;
    end
    if (rx_run) begin
      unique case (rx_phase_q) inside
        mbe_pkg::PH_DATA: begin
          rx_shift_d = rx_shift_q | (mbe_pkg::ByteW'(item_i.rx_pin) << rx_bits_q[2:0]);
          rx_bits_d  = rx_bits_inc;
        end
        mbe_pkg::PH_STOP: begin
          ferr       = !item_i.rx_pin;
          holding_d  = rx_shift_q;
          ready_d    = 1'b1;
          rx_irq     = cfg_i.rx_irq_enable;
          rx_bits_d  = '0;
          rx_shift_d = '0;
        end
        mbe_pkg::PH_START, mbe_pkg::PH_END: begin
          rx_shift_d = rx_shift_q;
        end
      endcase
    end
  end

  always_comb begin
    pending_d = pending_q | tx_irq | rx_irq;
    if (func == mbe_pkg::FUNC_CLR_IRQ) begin
      pending_d = 1'b0;
    end
  end

  always_comb begin
    res_d.tx_pin      = line_d;
    res_d.rx_data     = holding_d;
    res_d.rx_avail    = ready_d;
    res_d.tx_empty    = empty_d;
    res_d.irq_pending = pending_d;
    res_d.irq_signal  = tx_irq | rx_irq;
    res_d.frame_error = ferr;
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (take_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      tx_phase_q  <= mbe_pkg::PH_START;
      tx_bits_q   <= '0;
      tx_shift_q  <= '0;
      rx_phase_q  <= mbe_pkg::PH_START;
      rx_bits_q   <= '0;
      rx_shift_q  <= '0;
      holding_q   <= '0;
      ready_q     <= 1'b0;
      empty_q     <= 1'b1;
      pending_q   <= 1'b0;
      line_q      <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take_o) begin
        acc_q      <= acc_d;
        tx_phase_q <= tx_phase_d;
        tx_bits_q  <= tx_bits_d;
        tx_shift_q <= tx_shift_d;
        rx_phase_q <= rx_phase_d;
        rx_bits_q  <= rx_bits_d;
        rx_shift_q <= rx_shift_d;
        holding_q  <= holding_d;
        ready_q    <= ready_d;
        empty_q    <= empty_d;
        pending_q  <= pending_d;
        line_q     <= line_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// File: sv/mini_uart_bit_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mini UART bit engine
// UART transmit/receive bit machines stepped by tick items at the baud count.
// ----------------------------------------------------------------------------
// Path: the input register captures the item, then the result register is
// written from it. Throughput: one item per cycle while the result channel
// is not stalled; the result register and the input register each accept a
// new entry in the cycle their current one moves on.
// Reset: asynchronous, active low; all machines return to the start phase,
// the line idles high, the transmit buffer reads empty and both channels drain.
module mini_uart_bit_engine_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mbe_in_if.sink                             in_ch,
  mbe_out_if.source                          out_ch,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mbe_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  mbe_pkg::mbe_cfg_t    cfg;
  mbe_pkg::mbe_item_t   in_item, s1_item;
  mbe_pkg::mbe_result_t res;
  logic                 s1_valid, s1_take;

  assign in_item.func    = in_ch.func;
  assign in_item.cycles  = in_ch.cycles;
  assign in_item.rx_pin  = in_ch.rx_pin;
  assign in_item.tx_byte = in_ch.tx_byte;

  mbe_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mbe_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .in_item_i  (in_item),
    .take_i     (s1_take),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  mbe_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (s1_valid),
    .item_i       (s1_item),
    .take_o       (s1_take),
    .res_valid_o  (out_ch.valid),
    .res_ready_i  (out_ch.ready),
    .res_o        (res)
  );

  assign out_ch.tx_pin      = res.tx_pin;
  assign out_ch.rx_data     = res.rx_data;
  assign out_ch.rx_avail    = res.rx_avail;
  assign out_ch.tx_empty    = res.tx_empty;
  assign out_ch.irq_pending = res.irq_pending;
  assign out_ch.irq_signal  = res.irq_signal;
  assign out_ch.frame_error = res.frame_error;

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mini UART bit engine testbench
// Runs a table of directed items, then randomized traffic under several
// register settings. The bench predicts the status snapshot that follows
// every accepted item and checks the result channel against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mbe_pkg::*;

  localparam logic [CfgIdxW-1:0] RegNoSuch = 3'd7;

  localparam mbe_result_t ResIdle = '{tx_pin: 1'b1, rx_data: 8'h00, rx_avail: 1'b0,
                                      tx_empty: 1'b1, irq_pending: 1'b0,
                                      irq_signal: 1'b0, frame_error: 1'b0};
  localparam mbe_result_t ResLoaded = '{tx_pin: 1'b1, rx_data: 8'h00, rx_avail: 1'b0,
                                        tx_empty: 1'b0, irq_pending: 1'b0,
                                        irq_signal: 1'b0, frame_error: 1'b0};

  typedef struct {
    logic        load;
    mbe_cfg_t    cfg;
    mbe_item_t   item;
    logic        typed;
    mbe_result_t res;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  mbe_in_if  in_ch ();
  mbe_out_if out_ch ();

  mini_uart_bit_engine_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Predicted UART state and register copy.
  mbe_cfg_t         cfg_m = '{baud_count: '0, eight_bit_chars: 1'b0, tx_enable: 1'b1,
                              rx_enable: 1'b1, rx_irq_enable: 1'b0, tx_irq_enable: 1'b0,
                              uart_enable: 1'b0};
  logic [AccW-1:0]  acc_m = '0;
  mbe_phase_e       tx_ph = PH_START;
  mbe_phase_e       rx_ph = PH_START;
  logic [3:0]       tx_cnt = '0;
  logic [3:0]       rx_cnt = '0;
  logic [7:0]       tx_sr = '0;
  logic [7:0]       rx_sr = '0;
  logic [7:0]       rx_hold = '0;
  logic             ready_m = 1'b0;
  logic             empty_m = 1'b1;
  logic             pend_m = 1'b0;
  logic             line_m = 1'b1;

  mbe_result_t      want_status_q[$];
  mbe_result_t      want;
  plan_row_t        plan[$];
  int unsigned      fail_count = 0;
  int unsigned      rdy_mode = 0;
  int unsigned      rdy_left = 0;

  function automatic mbe_result_t uart_advance(input mbe_item_t it);
    mbe_result_t o;
    logic [3:0]  clen;
    logic        irq;
    logic        ferr;
    clen = cfg_m.eight_bit_chars ? LenLong : LenShort;
    irq  = 1'b0;
    ferr = 1'b0;
    case (mbe_func_e'(it.func))
      FUNC_TICK: begin
        acc_m = acc_m + AccW'(it.cycles);
        if (acc_m >= AccW'(cfg_m.baud_count)) begin
          acc_m = '0;
          if (cfg_m.uart_enable) begin
            // The transmitter steps first, then the receiver samples the pin.
            if (!empty_m && cfg_m.tx_enable) begin
              case (tx_ph)
                PH_START: begin
                  line_m = 1'b0;
                  tx_ph  = PH_DATA;
                end
                PH_DATA: begin
                  line_m = tx_sr[0];
                  tx_sr  = tx_sr >> 1;
                  tx_cnt = tx_cnt + 4'd1;
                  if (tx_cnt >= clen) tx_ph = PH_STOP;
                end
                PH_STOP: begin
                  line_m = 1'b1;
                  tx_ph  = PH_END;
                end
                default: begin
                  if (cfg_m.tx_irq_enable) begin
                    pend_m = 1'b1;
                    irq    = 1'b1;
                  end
                  tx_ph   = PH_START;
                  tx_cnt  = '0;
                  line_m  = 1'b1;
                  empty_m = 1'b1;
                end
              endcase
            end
            if (cfg_m.rx_enable) begin
              case (rx_ph)
                PH_START: begin
                  if (!it.rx_pin) rx_ph = PH_DATA;
                end
                PH_DATA: begin
                  rx_sr  = rx_sr | (8'(it.rx_pin) << rx_cnt[2:0]);
                  rx_cnt = rx_cnt + 4'd1;
                  if (rx_cnt >= clen) rx_ph = PH_STOP;
                end
                PH_STOP: begin
                  if (!it.rx_pin) ferr = 1'b1;
                  rx_hold = rx_sr;
                  ready_m = 1'b1;
                  if (cfg_m.rx_irq_enable) begin
                    pend_m = 1'b1;
                    irq    = 1'b1;
                  end
                  rx_ph  = PH_START;
                  rx_cnt = '0;
                  rx_sr  = '0;
                end
                default: rx_ph = PH_START;
              endcase
            end
          end
        end
      end
      FUNC_WRITE_TX: begin
        tx_sr   = it.tx_byte;
        empty_m = 1'b0;
      end
      FUNC_CLR_READY: ready_m = 1'b0;
      default: pend_m = 1'b0;
    endcase
    o.tx_pin      = line_m;
    o.rx_data     = rx_hold;
    o.rx_avail    = ready_m;
    o.tx_empty    = empty_m;
    o.irq_pending = pend_m;
    o.irq_signal  = irq;
    o.frame_error = ferr;
    return o;
  endfunction

  function automatic mbe_cfg_t mk_cfg(input logic [15:0] baud, input logic eight,
                                      input logic txe, input logic rxe, input logic rxi,
                                      input logic txi, input logic ue);
    mbe_cfg_t c;
    c.baud_count      = baud;
    c.eight_bit_chars = eight;
    c.tx_enable       = txe;
    c.rx_enable       = rxe;
    c.rx_irq_enable   = rxi;
    c.tx_irq_enable   = txi;
    c.uart_enable     = ue;
    return c;
  endfunction

  function automatic plan_row_t stim_row(input mbe_func_e f, input logic [7:0] cyc,
                                         input logic pin, input logic [7:0] txb,
                                         input logic typed = 1'b0,
                                         input mbe_result_t res = '0);
    plan_row_t p;
    p.load         = 1'b0;
    p.cfg          = '0;
    p.item.func    = f;
    p.item.cycles  = cyc;
    p.item.rx_pin  = pin;
    p.item.tx_byte = txb;
    p.typed        = typed;
    p.res          = res;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input mbe_cfg_t c);
    plan_row_t p;
    p      = stim_row(FUNC_TICK, 8'd0, 1'b1, 8'd0);
    p.load = 1'b1;
    p.cfg  = c;
    return p;
  endfunction

  // Single-bit registers only look at bit 0; the upper bits carry noise.
  function automatic logic [15:0] pad(input logic b);
    logic [15:0] r;
    r = 16'($urandom);
    return {r[15:1], b};
  endfunction

  function automatic void cmp(input string name, input logic [7:0] exp_v,
                              input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_BAUD_COUNT:      cfg_m.baud_count      = val;
      REG_EIGHT_BIT_CHARS: cfg_m.eight_bit_chars = val[0];
      REG_TX_ENABLE:       cfg_m.tx_enable       = val[0];
      REG_RX_ENABLE:       cfg_m.rx_enable       = val[0];
      REG_RX_IRQ_ENABLE:   cfg_m.rx_irq_enable   = val[0];
      REG_TX_IRQ_ENABLE:   cfg_m.tx_irq_enable   = val[0];
      REG_UART_ENABLE:     cfg_m.uart_enable     = val[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input mbe_cfg_t c);
    write_reg(REG_BAUD_COUNT, c.baud_count);
    write_reg(REG_EIGHT_BIT_CHARS, pad(c.eight_bit_chars));
    write_reg(REG_TX_ENABLE, pad(c.tx_enable));
    write_reg(RegNoSuch, 16'($urandom));
    write_reg(REG_RX_ENABLE, pad(c.rx_enable));
    write_reg(REG_RX_IRQ_ENABLE, pad(c.rx_irq_enable));
    write_reg(REG_TX_IRQ_ENABLE, pad(c.tx_irq_enable));
    write_reg(REG_UART_ENABLE, pad(c.uart_enable));
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (want_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_item(input mbe_item_t it, input logic typed, input mbe_result_t res);
    mbe_result_t p;
    in_ch.valid   <= 1'b1;
    in_ch.func    <= it.func;
    in_ch.cycles  <= it.cycles;
    in_ch.rx_pin  <= it.rx_pin;
    in_ch.tx_byte <= it.tx_byte;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    p = uart_advance(it);
    want_status_q.push_back(typed ? res : p);
  endtask

  // Result side: check each transfer, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (want_status_q.size() == 0) begin
        $error("result transfer with no expected status waiting");
        fail_count++;
      end else begin
        want = want_status_q.pop_front();
        cmp("tx_pin", 8'(want.tx_pin), 8'(out_ch.tx_pin));
        cmp("rx_data", want.rx_data, out_ch.rx_data);
        cmp("rx_avail", 8'(want.rx_avail), 8'(out_ch.rx_avail));
        cmp("tx_empty", 8'(want.tx_empty), 8'(out_ch.tx_empty));
        cmp("irq_pending", 8'(want.irq_pending), 8'(out_ch.irq_pending));
        cmp("irq_signal", 8'(want.irq_signal), 8'(out_ch.irq_signal));
        cmp("frame_error", 8'(want.frame_error), 8'(out_ch.frame_error));
      end
    end
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(8, 80);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (rdy_left % 16 == 0);
    endcase
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    mbe_item_t   it;
    mbe_cfg_t    c;
    logic        line_bits_q[$];
    logic [7:0]  cyc;
    logic [AccW-1:0] nxt;
    logic [3:0]  flen;
    logic        gapless;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned n_items;
    int unsigned r;

    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_TICK;
    in_ch.cycles  = '0;
    in_ch.rx_pin  = 1'b1;
    in_ch.tx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_BAUD_COUNT;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;

    // Out of reset the UART is disabled, so ticks leave the status untouched.
    plan.push_back(stim_row(FUNC_TICK, 8'd0, 1'b1, 8'h00, 1'b1, ResIdle));
    plan.push_back(stim_row(FUNC_TICK, 8'd255, 1'b0, 8'hFF, 1'b1, ResIdle));
    plan.push_back(stim_row(FUNC_CLR_READY, 8'd255, 1'b0, 8'hFF, 1'b1, ResIdle));
    plan.push_back(stim_row(FUNC_CLR_IRQ, 8'd255, 1'b1, 8'hFF, 1'b1, ResIdle));
    plan.push_back(stim_row(FUNC_WRITE_TX, 8'd0, 1'b0, 8'hA5, 1'b1, ResLoaded));
    // Zero baud count with 8-bit characters: the received stop bit and the
    // transmit end step land on the same tick, with a low stop bit.
    plan.push_back(cfg_row(mk_cfg(16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1)));
    plan.push_back(stim_row(FUNC_TICK, 8'd0, 1'b1, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd7, 1'b0, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd1, 1'b1, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd0, 1'b0, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd2, 1'b1, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd0, 1'b1, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd3, 1'b0, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd0, 1'b0, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd9, 1'b1, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd0, 1'b0, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd0, 1'b0, 8'h00));
    plan.push_back(stim_row(FUNC_CLR_READY, 8'd0, 1'b1, 8'h5A));
    plan.push_back(stim_row(FUNC_CLR_IRQ, 8'd0, 1'b0, 8'h5A));
    // Largest baud count: a few full ticks never reach it.
    plan.push_back(cfg_row(mk_cfg(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1)));
    plan.push_back(stim_row(FUNC_WRITE_TX, 8'd255, 1'b1, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd255, 1'b0, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd255, 1'b1, 8'h00));
    // Reload of the transmit byte while a frame is under way.
    plan.push_back(cfg_row(mk_cfg(16'd1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1)));
    plan.push_back(stim_row(FUNC_TICK, 8'd1, 1'b1, 8'h00));
    plan.push_back(stim_row(FUNC_TICK, 8'd0, 1'b0, 8'h00));
    plan.push_back(stim_row(FUNC_WRITE_TX, 8'd0, 1'b0, 8'hC3));
    plan.push_back(stim_row(FUNC_TICK, 8'd1, 1'b0, 8'h00));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].load) begin
        drain();
        load_config(plan[i].cfg);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].res);
      end
    end

    for (int ph = 0; ph < 11; ph++) begin
      c = mk_cfg(16'($urandom_range(0, 6)), 1'($urandom), ($urandom_range(0, 9) != 0),
                 ($urandom_range(0, 9) != 0), 1'($urandom), 1'($urandom), 1'b1);
      case (ph)
        0: c = mk_cfg(16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        1: c.baud_count = 16'hFFFF;
        2: c.uart_enable = 1'b0;
        3: c.tx_enable = 1'b0;
        4: c.rx_enable = 1'b0;
        5: c.baud_count = 16'd1;
        default: ;
      endcase
      gapless = (ph % 4 == 3);
      n_items = (ph == 1) ? 40 : 96;
      drain();
      load_config(c);
      burst_left = 0;
      repeat (n_items) begin
        if (!gapless && burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        if (burst_left != 0) burst_left--;

        r          = $urandom_range(0, 99);
        it.func    = FUNC_TICK;
        it.cycles  = 8'($urandom);
        it.rx_pin  = 1'($urandom);
        it.tx_byte = 8'($urandom);
        if (r < 8) begin
          it.func = 2'($urandom);
        end else if (r < 10 || (r < 20 && empty_m)) begin
          it.func = FUNC_WRITE_TX;
        end else if (r < 26 && ready_m) begin
          it.func = FUNC_CLR_READY;
        end else if (r < 31 && pend_m) begin
          it.func = FUNC_CLR_IRQ;
        end else begin
          if (cfg_m.baud_count > 32) begin
            cyc = ($urandom_range(0, 4) != 0) ? 8'd255 : 8'($urandom);
          end else begin
            cyc = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                               : 8'($urandom_range(0, 2 * cfg_m.baud_count + 1));
          end
          it.cycles = cyc;
          nxt = acc_m + AccW'(cyc);
          // On a bit step the pin follows a serial frame; otherwise it is noise.
          if (cfg_m.uart_enable && nxt >= AccW'(cfg_m.baud_count)) begin
            if (line_bits_q.size() == 0) begin
              repeat ($urandom_range(0, 2)) line_bits_q.push_back(1'b1);
              line_bits_q.push_back(1'b0);
              flen = cfg_m.eight_bit_chars ? LenLong : LenShort;
              repeat (flen) line_bits_q.push_back(1'($urandom));
              line_bits_q.push_back($urandom_range(0, 6) != 0);
            end
            it.rx_pin = line_bits_q.pop_front();
          end
        end
        send_item(it, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && want_status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mbe_pkg.sv
sv/mbe_in_if.sv
sv/mbe_out_if.sv
sv/mbe_cfg_regs.sv
sv/mbe_in_reg.sv
sv/mbe_engine.sv
sv/mini_uart_bit_engine_core.sv
test/tb_top.sv
